// ----- hdl/nmea_sentence_receiver_core_assert.svh -----
// Assertion macros for the NMEA sentence receiver core.
`ifndef NMEA_SENTENCE_RECEIVER_CORE_ASSERT_SVH
`define NMEA_SENTENCE_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NSR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nsr assertion failed");
`define NSR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsr implication failed");
`else
`define NSR_ASSERT(label, prop)
`define NSR_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ----- hdl/nsr_pkg.sv -----
// Shared types and constants of the NMEA sentence receiver.
`timescale 1ns / 1ps
package nsr_pkg;

    localparam int MAX_FIELDS  = 15;
    localparam int FIELD_CHARS = 16;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        EV_CHAR      = 2'd0,
        EV_FIELD_END = 2'd1,
        EV_DONE      = 2'd2,
        EV_ABORT     = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        CLS_OTHER  = 2'd0,
        CLS_DOLLAR = 2'd1,
        CLS_COMMA  = 2'd2,
        CLS_STAR   = 2'd3
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
        logic [3:0]  hex_val;
        logic        hex_bad;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  field_index;
        logic [3:0]  char_pos;
        logic [7:0]  char_value;
        logic [3:0]  field_count;
        logic        checksum_ok;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
    } result_t;

endpackage

// ----- hdl/nsr_front.sv -----
// Input side: accepts bytes, classifies them and decodes hex digits.
`timescale 1ns / 1ps
module nsr_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    input  nsr_pkg::queue_status_t q_status,
    output logic                  push,
    output nsr_pkg::item_t        push_item
);
    import nsr_pkg::*;

    logic [7:0] c;
    logic [7:0] diff;

    assign c        = s_tdata;
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_item.data    = c;
        push_item.hex_bad = 1'b0;
        diff              = 8'd0;
        if (c inside {[CH_ZERO : CH_ZERO + 8'd9]})
        begin
            diff = c - CH_ZERO;
        end
        else if (c inside {[CH_UPPER_A : CH_UPPER_A + 8'd5]})
        begin
            diff = c - CH_UPPER_A + 8'd10;
        end
        else if (c inside {[CH_LOWER_A : CH_LOWER_A + 8'd5]})
        begin
            diff = c - CH_LOWER_A + 8'd10;
        end
        else
        begin
            push_item.hex_bad = 1'b1;
        end
        push_item.hex_val = diff[3:0];

        case (c)
            CH_DOLLAR: push_item.cls = CLS_DOLLAR;
            CH_COMMA:  push_item.cls = CLS_COMMA;
            CH_STAR:   push_item.cls = CLS_STAR;
            default:   push_item.cls = CLS_OTHER;
        endcase
    end

endmodule

// ----- hdl/nsr_queue.sv -----
// Two-entry queue between the classifier and the sentence engine.
`timescale 1ns / 1ps
module nsr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  nsr_pkg::item_t         push_item,
    input  logic                   pop,
    output nsr_pkg::item_t         head_item,
    output nsr_pkg::queue_status_t q_status
);
    import nsr_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head_item      = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/nsr_back.sv -----
// Sentence engine: parse state, checksum and registered result output.
`timescale 1ns / 1ps
module nsr_back #(
    parameter int MAX_FIELDS  = nsr_pkg::MAX_FIELDS,
    parameter int FIELD_CHARS = nsr_pkg::FIELD_CHARS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   require_checksum,
    input  nsr_pkg::item_t         head_item,
    input  nsr_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output nsr_pkg::result_t       result
);
    import nsr_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_OPEN     = 4'b0010,
        MODE_SUM_HIGH = 4'b0100,
        MODE_SUM_LOW  = 4'b1000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [3:0] sum_high_reg, sum_high_next;
    logic [3:0] field_number_reg, field_number_next;
    logic [3:0] char_count_reg, char_count_next;
    logic       sum_bad_reg, sum_bad_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       take;
    logic       res_valid;
    result_t    res;
    logic [7:0] recv;
    logic       ok;

    assign take     = !q_status.empty && (!out_valid_reg || m_tready);
    assign pop      = take;
    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        mode_next         = mode_reg;
        running_sum_next  = running_sum_reg;
        sum_high_next     = sum_high_reg;
        field_number_next = field_number_reg;
        char_count_next   = char_count_reg;
        sum_bad_next      = sum_bad_reg;
        res_valid         = 1'b0;
        res               = '0;
        recv              = {sum_high_reg, head_item.hex_val};
        ok                = !(sum_bad_reg || head_item.hex_bad) && (recv == running_sum_reg);

        if (take)
        begin
            if (head_item.cls == CLS_DOLLAR)
            begin
                mode_next         = MODE_OPEN;
                running_sum_next  = 8'd0;
                sum_high_next     = 4'd0;
                field_number_next = 4'd0;
                char_count_next   = 4'd0;
                sum_bad_next      = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    MODE_OPEN:
                    begin
                        res.field_index = field_number_reg;
                        res.char_pos    = char_count_reg;
                        res_valid       = 1'b1;
                        if (head_item.cls == CLS_COMMA)
                        begin
                            running_sum_next = running_sum_reg ^ head_item.data;
                            if ({1'b0, field_number_reg} + 5'd1 >= 5'(MAX_FIELDS))
                            begin
                                mode_next = MODE_IDLE;
                                res.kind  = EV_ABORT;
                            end
                            else
                            begin
                                field_number_next = field_number_reg + 4'd1;
                                char_count_next   = 4'd0;
                                res.kind          = EV_FIELD_END;
                            end
                        end
                        else if (head_item.cls == CLS_STAR)
                        begin
                            field_number_next = field_number_reg + 4'd1;
                            mode_next         = MODE_SUM_HIGH;
                            res.kind          = EV_FIELD_END;
                        end
                        else
                        begin
                            running_sum_next = running_sum_reg ^ head_item.data;
                            if ({1'b0, char_count_reg} < 5'(FIELD_CHARS - 1))
                            begin
                                char_count_next = char_count_reg + 4'd1;
                                res.kind        = EV_CHAR;
                                res.char_value  = head_item.data;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                                res.kind  = EV_ABORT;
                            end
                        end
                    end
                    MODE_SUM_HIGH:
                    begin
                        sum_high_next = head_item.hex_val;
                        sum_bad_next  = head_item.hex_bad;
                        mode_next     = MODE_SUM_LOW;
                    end
                    MODE_SUM_LOW:
                    begin
                        mode_next        = MODE_IDLE;
                        res_valid        = 1'b1;
                        res.kind         = (require_checksum && !ok) ? EV_ABORT : EV_DONE;
                        res.field_count  = field_number_reg;
                        res.checksum_ok  = ok;
                        res.computed_sum = running_sum_reg;
                        res.received_sum = recv;
                    end
                    MODE_IDLE:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end

        if (take && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            running_sum_reg  <= 8'd0;
            sum_high_reg     <= 4'd0;
            field_number_reg <= 4'd0;
            char_count_reg   <= 4'd0;
            sum_bad_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            running_sum_reg  <= running_sum_next;
            sum_high_reg     <= sum_high_next;
            field_number_reg <= field_number_next;
            char_count_reg   <= char_count_next;
            sum_bad_reg      <= sum_bad_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule

// ----- hdl/nmea_sentence_receiver_core.sv -----
// Top level of the NMEA 0183 sentence receiver.
//
//   channel   dir  width  content
//   s_*       in   8      rx_byte per transfer
//   m_*       out  40+2   one event per transfer (kind in tuser)
//   cfg_*     in   1      require_checksum
//
// One byte per cycle while m_tready is high; the engine updates its mode and
// counters once per byte. A byte passes through the queue entry, then the
// output register. A two-entry queue lets input keep flowing for two bytes
// while m_tready is low. Reset clears all parse state and the config bit.
`timescale 1ns / 1ps
`include "nmea_sentence_receiver_core_assert.svh"
module nmea_sentence_receiver_core #(
    parameter int MAX_FIELDS  = nsr_pkg::MAX_FIELDS,
    parameter int FIELD_CHARS = nsr_pkg::FIELD_CHARS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // field_index, char_pos, char_value, field_count,
                                   // checksum_ok, computed_sum, received_sum, zero pad
    output logic [1:0]  m_tuser,   // event_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // require_checksum
);
    import nsr_pkg::*;

    logic          require_checksum_reg, require_checksum_next;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    item_t         push_item;
    item_t         head_item;
    result_t       result;

    assign cfg_ready             = 1'b1;
    assign require_checksum_next = (cfg_valid && cfg_ready) ? cfg_data : require_checksum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_checksum_reg <= 1'b0;
        end
        else
        begin
            require_checksum_reg <= require_checksum_next;
        end
    end

    nsr_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    nsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    nsr_back #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .require_checksum (require_checksum_reg),
        .head_item        (head_item),
        .q_status         (q_status),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .result           (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {3'b000, result.received_sum, result.computed_sum, result.checksum_ok,
                      result.field_count, result.char_value, result.char_pos,
                      result.field_index};

    `NSR_ASSERT(a_pop_not_empty, !(pop && q_status.empty))
    `NSR_ASSERT_IMPL(a_char_clean, m_tvalid && m_tuser == EV_CHAR, m_tdata[39:16] == 24'd0)
    `NSR_ASSERT_IMPL(a_done_clean, m_tvalid && m_tuser == EV_DONE, m_tdata[15:0] == 16'd0)

endmodule
